### src/lru_ot_pkg.sv
package lru_ot_pkg;

  // Request kinds
  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EVICT  = 2'd2;

  // Result status codes
  localparam logic [2:0] STATUS_HIT      = 3'd0;
  localparam logic [2:0] STATUS_INSERTED = 3'd1;
  localparam logic [2:0] STATUS_REMOVED  = 3'd2;
  localparam logic [2:0] STATUS_ABSENT   = 3'd3;
  localparam logic [2:0] STATUS_EVICTED  = 3'd4;
  localparam logic [2:0] STATUS_NO_EVICT = 3'd5;
  localparam logic [2:0] STATUS_FULL     = 3'd6;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_MAX_ENTRIES = 1'b0;
  localparam logic [4:0]  MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] evicted_key;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic apply;
  } ctrl_cmd_t;

endpackage

### src/lru_ot_ctrl.sv
module lru_ot_ctrl import lru_ot_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   look_q;
  logic   apply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      look_q  <= 1'b0;
      apply_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_LOOK;
            busy_q  <= 1'b1;
            look_q  <= 1'b1;
          end
        end
        S_LOOK: begin
          state_q <= S_APPLY;
          look_q  <= 1'b0;
          apply_q <= 1'b1;
        end
        S_APPLY: begin
          state_q <= S_IDLE;
          apply_q <= 1'b0;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          look_q  <= 1'b0;
          apply_q <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o        = busy_q;
  assign cmd_o.capture = start_i && (state_q == S_IDLE);
  assign cmd_o.look    = look_q;
  assign cmd_o.apply   = apply_q;

endmodule

### src/lru_ot_datapath.sv
module lru_ot_datapath import lru_ot_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_W    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  req_t       req_i,
  input  logic [4:0] max_entries_i,
  output rsp_t       rsp_o,
  output logic       rsp_valid_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // Transaction held for the duration of the lookup and update
  logic [1:0]       kind_q;
  logic [KEY_W-1:0] key_q;

  logic [KEY_W-1:0] tag_q  [CAPACITY];
  logic [IDX_W-1:0] rank_q [CAPACITY];
  logic [IDX_W-1:0] rank_d [CAPACITY];
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [CNT_W-1:0] count_q, count_d;

  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q;

  logic [IDX_W-1:0]    last_rank;
  logic [IDX_W-1:0]    sel_rank;
  logic [KEY_W-1:0]    sel_tag;
  logic [CAPACITY-1:0] free_oh;
  logic hit, free_any, evict_ok;
  logic do_promote, do_insert, do_drop;

  // Lookup: parallel tag compare, or find the least recent slot for evict
  assign last_rank = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (kind_q == KIND_EVICT) begin
        match_d[i] = valid_q[i] && (rank_q[i] == last_rank);
      end else begin
        match_d[i] = valid_q[i] && (tag_q[i] == key_q);
      end
    end
  end

  // Update: match vector is one-hot or empty, so an AND-OR picks the entry
  always_comb begin
    sel_rank = '0;
    sel_tag  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) begin
        sel_rank = sel_rank | rank_q[i];
        sel_tag  = sel_tag | tag_q[i];
      end
    end
  end

  // lowest free slot, isolated by a carry
  assign free_oh  = ~valid_q & (valid_q + CAPACITY'(1));
  assign free_any = |free_oh;
  assign hit      = |match_q;
  assign evict_ok = (count_q != '0) && (CMP_W'(count_q) >= CMP_W'(max_entries_i));

  assign do_promote = (kind_q == KIND_ACCESS) && hit;
  assign do_insert  = (kind_q == KIND_ACCESS) && !hit && free_any;
  assign do_drop    = ((kind_q == KIND_REMOVE) && hit) ||
                      ((kind_q == KIND_EVICT) && evict_ok && hit);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
      if (do_promote) begin
        if (match_q[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < sel_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end else if (do_insert) begin
        if (free_oh[i]) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end else if (do_drop) begin
        if (match_q[i]) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end else if (valid_q[i] && (rank_q[i] > sel_rank)) begin
          rank_d[i] = rank_q[i] - IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_drop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d.evicted_key = '0;
    rsp_d.entry_count = 5'(count_d);
    case (kind_q)
      KIND_ACCESS: begin
        if (hit) begin
          rsp_d.status = STATUS_HIT;
        end else if (free_any) begin
          rsp_d.status = STATUS_INSERTED;
        end else begin
          rsp_d.status = STATUS_FULL;
        end
      end
      KIND_REMOVE: rsp_d.status = hit ? STATUS_REMOVED : STATUS_ABSENT;
      KIND_EVICT: begin
        if (do_drop) begin
          rsp_d.status      = STATUS_EVICTED;
          rsp_d.evicted_key = 32'(sel_tag);
        end else begin
          rsp_d.status = STATUS_NO_EVICT;
        end
      end
      default: rsp_d.status = STATUS_NO_EVICT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      rsp_valid_q <= cmd_i.apply;
      if (cmd_i.apply) begin
        valid_q <= valid_d;
        count_q <= count_d;
        for (int i = 0; i < CAPACITY; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_i.kind;
      key_q  <= KEY_W'(req_i.key);
    end
    if (cmd_i.look) begin
      match_q <= match_d;
    end
    if (cmd_i.apply) begin
      rsp_q <= rsp_d;
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_insert && free_oh[i]) begin
          tag_q[i] <= key_q;
        end
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

### src/lru_order_tracker.sv
// LRU replacement tracker: keeps the recency order of up to CAPACITY key tags.
// Command channel: drive req_i (kind, key) with start_i; the transaction is
// taken at the rising edge where start_i is high and busy_o is low.
//   access: promote a present key to most recent, or insert an absent one in
//           the lowest free slot (flagged full when no slot is free).
//   remove: drop a present key.  evict: drop and return the least recent key
//           once the entry count has reached max_entries.
// Result channel: rsp_o is valid for exactly one cycle, marked by rsp_valid_o,
// with status, evicted key (zero unless evicted) and the new entry count.
// Steps: the request is captured, the parallel tag compare is registered into
// match_q, then the rank update and the result are registered together.
// A new start is not taken while a transaction is in flight; it is taken in the
// cycle in which the previous result is strobed.
// The receiver cannot stall; results are never held back.
// Reset empties the tracker (all slots invalid, count zero) and sets
// max_entries to 16. No clearing pass is needed; start may follow reset.
// APB register at byte address 0: max_entries (5 bits). Write only while idle.
module lru_order_tracker import lru_ot_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_W    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  req_t               req_i,
  output rsp_t               rsp_o,
  output logic               rsp_valid_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ctrl_cmd_t  cmd;
  logic [4:0] max_entries_q;
  logic       reg_sel;

  assign reg_sel = (paddr[2] == REG_MAX_ENTRIES);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {27'd0, max_entries_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_entries_q <= pwdata[4:0];
    end
  end

  lru_ot_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  lru_ot_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i),
    .max_entries_i (max_entries_q),
    .rsp_o         (rsp_o),
    .rsp_valid_o   (rsp_valid_o)
  );

endmodule

### src/lru_ot_checker.sv
module lru_ot_checker import lru_ot_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input rsp_t rsp_o,
  input logic rsp_valid_o
);

  // every accepted transaction gives its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 rsp_valid_o)
    else $error("result missing after accepted transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 busy_o)
    else $error("busy dropped while transaction in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != STATUS_EVICTED)) |-> (rsp_o.evicted_key == 32'd0))
    else $error("evicted key set without eviction");

endmodule

bind lru_order_tracker lru_ot_checker u_checker (.*);
